// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands; expect clk and rst_n in the enclosing scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/ffra_pkg.sv
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared types and constants of the first-fit region allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffra_pkg;

  localparam int REQ_SIZE_W    = 32;
  localparam int REL_START_W   = 32;
  localparam int GRANT_START_W = 32;
  localparam int GRANT_END_W   = 33;
  localparam int PAGES_W       = 17;
  localparam int PAGE_SHIFT    = 16;

  localparam logic [PAGE_SHIFT-1:0] PAGE_ROUND = '1;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ZERO     = 3'd1,
    ST_FULL     = 3'd2,
    ST_LIMIT    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPEND,
    S_RESP
  } state_t;

  typedef struct packed {
    logic accept;
    logic scan;
    logic append;
    logic load_out;
  } ffra_cmd_t;

  typedef struct packed {
    logic early_done;
    logic go_append;
    logic scan_last;
    logic scan_append;
    logic out_busy;
  } ffra_sts_t;

endpackage

`default_nettype wire

// File: rtl/ffra_req_if.sv
// ----------------------------------------------------------------------------
// ffra_req_if
// Request channel: allocate or free, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffra_req_if
  import ffra_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic                   kind;
  logic [REQ_SIZE_W-1:0]  request_size;
  logic [REL_START_W-1:0] release_start;

  modport source (output valid, kind, request_size, release_start, input ready);
  modport sink   (input valid, kind, request_size, release_start, output ready);
endinterface

`default_nettype wire

// File: rtl/ffra_rsp_if.sv
// ----------------------------------------------------------------------------
// ffra_rsp_if
// Result channel: status, granted region and pages in use.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffra_rsp_if
  import ffra_pkg::*;
();
  logic                     valid;
  logic                     ready;
  status_t                  status;
  logic [GRANT_START_W-1:0] granted_start;
  logic [GRANT_END_W-1:0]   granted_end;
  logic [PAGES_W-1:0]       pages_in_use;

  modport source (output valid, status, granted_start, granted_end, pages_in_use,
                  input ready);
  modport sink   (input valid, status, granted_start, granted_end, pages_in_use,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/ffra_ram.sv
// ----------------------------------------------------------------------------
// ffra_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ffra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/ffra_ctrl.sv
// ----------------------------------------------------------------------------
// ffra_ctrl
// Request sequencer: accept, table scan, append, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module ffra_ctrl
  import ffra_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire ffra_sts_t sts,
  output ffra_cmd_t      cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          priority if (sts.early_done) begin
            state_nxt = S_RESP;
          end else if (sts.go_append) begin
            state_nxt = S_APPEND;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = sts.scan_append ? S_APPEND : S_RESP;
        end
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_nxt  = S_RESP;
      end
      S_RESP: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/ffra_dp.sv
// ----------------------------------------------------------------------------
// ffra_dp
// Region table datapath: walk, first-fit test, in-place shift, result regs.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ffra_dp
  import ffra_pkg::*;
#(
  parameter int MAX_REGIONS  = 16,
  parameter int ADDRESS_BITS = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire ffra_cmd_t                cmd,
  output ffra_sts_t                     sts,
  input  wire logic                     in_kind,
  input  wire logic [REQ_SIZE_W-1:0]    in_request_size,
  input  wire logic [REL_START_W-1:0]   in_release_start,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output status_t                       out_status,
  output logic      [GRANT_START_W-1:0] out_granted_start,
  output logic      [GRANT_END_W-1:0]   out_granted_end,
  output logic      [PAGES_W-1:0]       out_pages_in_use
);

  localparam int AW = $clog2(MAX_REGIONS);
  localparam int CW = $clog2(MAX_REGIONS + 1);
  localparam int SW = ADDRESS_BITS;
  localparam int NW = ADDRESS_BITS + 1;
  localparam int EW = SW + NW;
  localparam int WW = ((ADDRESS_BITS > REQ_SIZE_W) ? ADDRESS_BITS : REQ_SIZE_W) + 2;
  localparam int PW = ADDRESS_BITS + 18;

  localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_REGIONS);
  localparam logic [WW-1:0] LIMIT_W   = WW'(1) << ADDRESS_BITS;

  // request and walk registers
  logic                   kind_r;
  logic [REQ_SIZE_W-1:0]  size_r;
  logic [REL_START_W-1:0] rel_r;
  logic [CW-1:0]          p_r, p_nxt;
  logic [NW-1:0]          base_r, base_nxt;
  logic [EW-1:0]          carry_r, carry_nxt;
  logic                   found_r, found_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [NW-1:0]          last_end_r, last_end_nxt;

  // pending result
  status_t                  res_status_r, res_status_nxt;
  logic [GRANT_START_W-1:0] res_gs_r, res_gs_nxt;
  logic [GRANT_END_W-1:0]   res_ge_r, res_ge_nxt;

  // output register
  logic                     out_valid_r;
  status_t                  out_status_r;
  logic [GRANT_START_W-1:0] out_gs_r;
  logic [GRANT_END_W-1:0]   out_ge_r;
  logic [PAGES_W-1:0]       out_pages_r;

  // memory port
  logic          we;
  logic [CW-1:0] wr_ptr;
  logic [EW-1:0] wdata;
  logic [AW-1:0] raddr;
  logic [EW-1:0] rdata;

  logic [SW-1:0] rd_start;
  logic [NW-1:0] rd_end;
  logic [WW-1:0] base_w, size_w, sum_w, start_w;
  logic          fits, match;
  logic [CW-1:0] p_inc;
  logic          p_last;
  logic [PW-1:0] pg_sum;
  status_t       early_status;
  logic          go_append;

  ffra_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_REGIONS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (wr_ptr[AW-1:0]),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_start = rdata[EW-1:NW];
  assign rd_end   = rdata[NW-1:0];
  assign base_w   = WW'(base_r);
  assign size_w   = WW'(size_r);
  assign sum_w    = base_w + size_w;
  assign start_w  = WW'(rd_start);
  assign fits     = (start_w >= base_w) && ((start_w - base_w) >= size_w);
  assign match    = (start_w == WW'(rel_r));
  assign p_inc    = p_r + CW'(1);
  assign p_last   = (p_r == (count_r - CW'(1)));
  assign raddr    = cmd.scan ? p_inc[AW-1:0] : '0;

  // request screening at accept time
  always_comb begin
    early_status = ST_OK;
    go_append    = 1'b0;
    if (in_kind == KIND_ALLOC) begin
      priority if (in_request_size == '0) begin
        early_status = ST_ZERO;
      end else if (count_r == COUNT_MAX) begin
        early_status = ST_FULL;
      end else if (count_r == '0) begin
        go_append = 1'b1;
      end
    end else if (count_r == '0) begin
      early_status = ST_NOTFOUND;
    end
  end

  // status to the controller, from registered state and the request and out_ready inputs
  always_comb begin
    sts            = '0;
    sts.early_done = (early_status != ST_OK);
    sts.go_append  = go_append;
    sts.out_busy   = out_valid_r && !out_ready;
    if (kind_r == KIND_ALLOC) begin
      if (!found_r) begin
        if (!fits && (p_inc == count_r)) begin
          sts.scan_last   = 1'b1;
          sts.scan_append = 1'b1;
        end
      end else if (p_r == count_r) begin
        sts.scan_last = 1'b1;
      end
    end else if (p_last) begin
      sts.scan_last = 1'b1;
    end
  end

  always_comb begin
    p_nxt          = p_r;
    base_nxt       = base_r;
    carry_nxt      = carry_r;
    found_nxt      = found_r;
    count_nxt      = count_r;
    last_end_nxt   = last_end_r;
    res_status_nxt = res_status_r;
    res_gs_nxt     = res_gs_r;
    res_ge_nxt     = res_ge_r;
    we             = 1'b0;
    wr_ptr         = p_r;
    wdata          = carry_r;

    if (cmd.accept) begin
      p_nxt          = '0;
      base_nxt       = '0;
      found_nxt      = 1'b0;
      res_status_nxt = early_status;
      res_gs_nxt     = '0;
      res_ge_nxt     = '0;
    end

    if (cmd.scan) begin
      if (kind_r == KIND_ALLOC) begin
        if (!found_r) begin
          if (fits) begin
            // insert here, old entry rides along in carry
            we             = 1'b1;
            wdata          = {base_r[SW-1:0], sum_w[NW-1:0]};
            carry_nxt      = rdata;
            found_nxt      = 1'b1;
            res_status_nxt = ST_OK;
            res_gs_nxt     = base_w[GRANT_START_W-1:0];
            res_ge_nxt     = sum_w[GRANT_END_W-1:0];
            p_nxt          = p_inc;
          end else begin
            base_nxt = rd_end;
            p_nxt    = p_inc;
          end
        end else begin
          we        = 1'b1;
          carry_nxt = rdata;
          if (p_r == count_r) begin
            count_nxt = count_r + CW'(1);
          end else begin
            p_nxt = p_inc;
          end
        end
      end else begin
        if (!found_r) begin
          if (match) begin
            found_nxt      = 1'b1;
            res_status_nxt = ST_OK;
            if (p_last) begin
              count_nxt    = count_r - CW'(1);
              last_end_nxt = base_r;
            end else begin
              p_nxt = p_inc;
            end
          end else begin
            base_nxt = rd_end;
            if (p_last) begin
              res_status_nxt = ST_NOTFOUND;
            end else begin
              p_nxt = p_inc;
            end
          end
        end else begin
          // pull entry down over the removed slot
          we     = 1'b1;
          wr_ptr = p_r - CW'(1);
          wdata  = rdata;
          if (p_last) begin
            count_nxt = count_r - CW'(1);
          end else begin
            p_nxt = p_inc;
          end
        end
      end
    end

    if (cmd.append) begin
      if (sum_w > LIMIT_W) begin
        res_status_nxt = ST_LIMIT;
      end else begin
        we             = 1'b1;
        wr_ptr         = count_r;
        wdata          = {base_r[SW-1:0], sum_w[NW-1:0]};
        count_nxt      = count_r + CW'(1);
        last_end_nxt   = sum_w[NW-1:0];
        res_status_nxt = ST_OK;
        res_gs_nxt     = base_w[GRANT_START_W-1:0];
        res_ge_nxt     = sum_w[GRANT_END_W-1:0];
      end
    end
  end

  assign pg_sum = PW'(last_end_r) + PW'(PAGE_ROUND);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      last_end_r  <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r    <= count_nxt;
      last_end_r <= last_end_nxt;
      found_r    <= found_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r <= in_kind;
      size_r <= in_request_size;
      rel_r  <= in_release_start;
    end
    p_r          <= p_nxt;
    base_r       <= base_nxt;
    carry_r      <= carry_nxt;
    res_status_r <= res_status_nxt;
    res_gs_r     <= res_gs_nxt;
    res_ge_r     <= res_ge_nxt;
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_gs_r     <= res_gs_r;
      out_ge_r     <= res_ge_r;
      out_pages_r  <= pg_sum[PAGE_SHIFT +: PAGES_W];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_granted_start = out_gs_r;
  assign out_granted_end   = out_ge_r;
  assign out_pages_in_use  = out_pages_r;

  `ASSERT_ALWAYS(a_count_range, count_r <= COUNT_MAX, "region count above table depth")
  `ASSERT_IMPL(a_empty_no_end, count_r == '0, last_end_r == '0, "empty table with nonzero end")
  `ASSERT_IMPL(a_wr_in_range, we, wr_ptr < COUNT_MAX, "table write beyond depth")
  `ASSERT_NEXT(a_count_quiet, !(cmd.scan || cmd.append), $stable(count_r),
               "region count moved outside scan or append")

endmodule

`default_nettype wire

// File: rtl/first_fit_region_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_region_allocator
// First-fit address region allocator with a sorted region table.
// ----------------------------------------------------------------------------
// One request is handled at a time. A zero size, a full table, or a free on
// an empty table is settled at accept without a table walk, and an allocate
// into an empty table is appended directly. Otherwise a single pass walks
// the region table, which sits in one RAM, one entry per cycle, testing the
// gap for first fit and shifting entries up on insert or down on free in the
// same pass. The result register frees the request side, so the next
// request is taken while a result still waits.
// The table needs no clearing after reset.
`default_nettype none

module first_fit_region_allocator
  import ffra_pkg::*;
#(
  parameter int MAX_REGIONS  = 16,
  parameter int ADDRESS_BITS = 32
) (
  input wire logic      clk,
  input wire logic      rst_n,
  ffra_req_if.sink      in_req,
  ffra_rsp_if.source    out_rsp
);

  ffra_cmd_t cmd;
  ffra_sts_t sts;

  ffra_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ffra_dp #(
    .MAX_REGIONS  (MAX_REGIONS),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_kind           (in_req.kind),
    .in_request_size   (in_req.request_size),
    .in_release_start  (in_req.release_start),
    .out_valid         (out_rsp.valid),
    .out_ready         (out_rsp.ready),
    .out_status        (out_rsp.status),
    .out_granted_start (out_rsp.granted_start),
    .out_granted_end   (out_rsp.granted_end),
    .out_pages_in_use  (out_rsp.pages_in_use)
  );

endmodule

`default_nettype wire

// File: test/first_fit_region_allocator_tb.sv
// ----------------------------------------------------------------------------
// first_fit_region_allocator_tb
// Drives allocate and free requests into the region allocator and checks
// every result against an internal first-fit table model. A short directed
// run covers empty, exact-fit, address-limit and full-table corners. Random
// grow and shrink phases follow. The sender idles in bursts, the receiver
// stalls on its own pattern and backs off once for a long stretch.
// ----------------------------------------------------------------------------
module first_fit_region_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ffra_pkg::*;

  localparam int REGION_SLOTS = 16;
  localparam int ADDR_BITS    = 32;
  localparam int RANDOM_ITEMS = 650;

  typedef struct {
    status_t                  status;
    logic [GRANT_START_W-1:0] gstart;
    logic [GRANT_END_W-1:0]   gend;
    logic [PAGES_W-1:0]       pages;
  } region_result_t;

  class region_scoreboard;
    bit [31:0]      starts [REGION_SLOTS];
    bit [32:0]      ends [REGION_SLOTS];
    int unsigned    used;
    int unsigned    errors;
    region_result_t expected [$];

    function new();
      used   = 0;
      errors = 0;
    endfunction

    function int unsigned region_total();
      return used;
    endfunction

    function int unsigned pending();
      return expected.size();
    endfunction

    function bit [31:0] pick_start();
      return starts[$urandom_range(0, used - 1)];
    endfunction

    function status_t place_region(bit [31:0] size, output bit [31:0] gs,
                                   output bit [32:0] ge);
      bit [63:0] base;
      bit [63:0] top;
      int        pos;
      gs   = '0;
      ge   = '0;
      base = '0;
      top  = 64'd1 << ADDR_BITS;
      if (size == 0) return ST_ZERO;
      if (used >= REGION_SLOTS) return ST_FULL;
      for (pos = 0; pos < used; pos++) begin
        if (starts[pos] >= base && starts[pos] - base >= size) break;
        base = ends[pos];
      end
      if (base > top || size > top - base) return ST_LIMIT;
      for (int j = used; j > pos; j--) begin
        starts[j] = starts[j-1];
        ends[j]   = ends[j-1];
      end
      starts[pos] = base[31:0];
      ends[pos]   = base[32:0] + size;
      used++;
      gs = base[31:0];
      ge = base[32:0] + size;
      return ST_OK;
    endfunction

    function status_t drop_region(bit [31:0] addr);
      int pos;
      for (pos = 0; pos < used; pos++) begin
        if (starts[pos] == addr) break;
      end
      if (pos >= used) return ST_NOTFOUND;
      for (int j = pos; j + 1 < used; j++) begin
        starts[j] = starts[j+1];
        ends[j]   = ends[j+1];
      end
      used--;
      return ST_OK;
    endfunction

    function void note_request(logic kind, logic [31:0] size, logic [31:0] rel);
      region_result_t r;
      bit [31:0]      gs;
      bit [32:0]      ge;
      bit [63:0]      last;
      if (kind == KIND_ALLOC) r.status = place_region(size, gs, ge);
      else begin
        r.status = drop_region(rel);
        gs = '0;
        ge = '0;
      end
      r.gstart = gs;
      r.gend   = ge;
      r.pages  = '0;
      if (used != 0) begin
        last    = 64'(ends[used-1]);
        r.pages = PAGES_W'((last + 64'hFFFF) >> PAGE_SHIFT);
      end
      expected.insert(expected.size(), r);
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    task check_result(status_t st, logic [GRANT_START_W-1:0] gs,
                      logic [GRANT_END_W-1:0] ge, logic [PAGES_W-1:0] pg);
      region_result_t e;
      if (expected.size() == 0) begin
        report_mismatch("result with no request outstanding");
        return;
      end
      e = expected.pop_front();
      if (st !== e.status)
        report_mismatch($sformatf("status %0d, want %0d", st, e.status));
      if (gs !== e.gstart)
        report_mismatch($sformatf("granted_start %h, want %h", gs, e.gstart));
      if (ge !== e.gend)
        report_mismatch($sformatf("granted_end %h, want %h", ge, e.gend));
      if (pg !== e.pages)
        report_mismatch($sformatf("pages_in_use %0d, want %0d", pg, e.pages));
    endtask

    task final_check();
      if (expected.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", expected.size()));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  ffra_req_if req_if ();
  ffra_rsp_if rsp_if ();

  region_scoreboard sb;

  int unsigned burst_left;
  int unsigned results_seen;
  int unsigned hold_left;
  bit          hold_done;
  int unsigned pattern_left;
  int unsigned pattern_mode;
  int unsigned cycle_cnt;

  first_fit_region_allocator #(
    .MAX_REGIONS (REGION_SLOTS),
    .ADDRESS_BITS(ADDR_BITS)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_if),
    .out_rsp(rsp_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("first_fit_region_allocator_tb: FAIL");
    $finish;
  end

  task automatic send_request(input logic kind, input logic [31:0] size,
                              input logic [31:0] rel);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    req_if.valid         <= 1'b1;
    req_if.kind          <= kind;
    req_if.request_size  <= size;
    req_if.release_start <= rel;
    do @(posedge clk); while (!req_if.ready);
    sb.note_request(kind, size, rel);
  endtask

  // result side: checking and stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
    end else begin
      cycle_cnt++;
      if (rsp_if.valid && rsp_if.ready) begin
        sb.check_result(rsp_if.status, rsp_if.granted_start, rsp_if.granted_end,
                        rsp_if.pages_in_use);
        results_seen++;
      end
      if (results_seen == 100 && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        if (pattern_left == 0) begin
          pattern_mode = $urandom_range(0, 3);
          pattern_left = $urandom_range(20, 200);
        end
        pattern_left--;
        case (pattern_mode)
          0: rsp_if.ready <= 1'b1;
          1: rsp_if.ready <= 1'($urandom_range(0, 1));
          2: rsp_if.ready <= (cycle_cnt % 4 == 0);
          default: rsp_if.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  initial begin
    logic        kind;
    logic [31:0] size;
    logic [31:0] rel;
    int unsigned roll;
    int unsigned pick;
    bit          growing;

    sb                   = new();
    burst_left           = 0;
    results_seen         = 0;
    hold_left            = 0;
    hold_done            = 1'b0;
    pattern_left         = 0;
    pattern_mode         = 0;
    cycle_cnt            = 0;
    growing              = 1'b0;
    rst_n                = 1'b0;
    req_if.valid         = 1'b0;
    req_if.kind          = KIND_ALLOC;
    req_if.request_size  = '0;
    req_if.release_start = '0;
    rsp_if.ready         = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed corners
    send_request(KIND_ALLOC, 32'h0, '0);
    send_request(KIND_FREE, '0, 32'h0);
    send_request(KIND_ALLOC, 32'hFFFF_FFFF, '0);
    send_request(KIND_ALLOC, 32'h1, '0);          // ends exactly at the limit
    send_request(KIND_ALLOC, 32'h1, '0);          // past the limit
    send_request(KIND_FREE, '0, 32'hFFFF_FFFF);
    send_request(KIND_FREE, '0, 32'h0);
    send_request(KIND_ALLOC, 32'h1_0000, '0);
    send_request(KIND_ALLOC, 32'h1, '0);
    send_request(KIND_FREE, '0, 32'h0);
    send_request(KIND_ALLOC, 32'h8000, '0);
    send_request(KIND_ALLOC, 32'h8000, '0);       // exact fit into the hole
    repeat (13) send_request(KIND_ALLOC, 32'h100, '0);
    send_request(KIND_ALLOC, 32'h100, '0);        // table full
    send_request(KIND_ALLOC, 32'h0, '0);          // zero wins over full

    // random grow and shrink phases
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) growing = !growing;
      roll = $urandom_range(0, 99);
      kind = KIND_ALLOC;
      size = $urandom;
      rel  = $urandom;
      if (roll < (growing ? 15 : 55) && sb.region_total() != 0) begin
        kind = KIND_FREE;
        rel  = sb.pick_start();
      end else if (roll < (growing ? 25 : 65)) begin
        kind = KIND_FREE;
        if ($urandom_range(0, 1) && sb.region_total() != 0) rel = sb.pick_start() + 1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 3) size = '0;
        else if (pick < 10) size = $urandom;
        else if (pick < 30) size = $urandom_range(1, 16) << PAGE_SHIFT;
        else size = $urandom_range(1, 32'h0002_0000);
      end
      send_request(kind, size, rel);
    end

    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    sb.final_check();
    if (sb.errors == 0) begin
      $display("first_fit_region_allocator_tb: PASS");
    end else begin
      $display("first_fit_region_allocator_tb: FAIL");
    end
    $finish;
  end

endmodule
